[rtl/core/mlpswu_pkg.sv]
// shared types, constants and the sigmoid table for the synaptic weight update block
// no dependencies
package mlpswu_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int SIG_N      = 256;
  localparam int SIG_IDX_W  = $clog2(SIG_N);
  localparam int ACC_W      = 48;
  localparam int COEF_COUNT = 52;
  localparam int COEF_AW    = 6;

  // coefficient map
  localparam logic [COEF_AW-1:0] L2_PRE_BASE  = 6'd32;
  localparam logic [COEF_AW-1:0] L2_POST_BASE = 6'd40;
  localparam logic [COEF_AW-1:0] OUT_PRE_BASE = 6'd48;
  localparam logic [COEF_AW-1:0] OUT_POST_BASE = 6'd50;

  // configuration register indexes
  localparam logic CFG_LEARN_RATE = 1'b0;
  localparam logic CFG_MAX_WEIGHT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_PRE    = 2'd1,
    FUNC_POST   = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_e;

  // request to the shared multiply-accumulate unit
  typedef struct packed {
    logic signed [31:0]      a;
    logic signed [31:0]      b;
    logic signed [ACC_W-1:0] addend;
    logic                    short_shift;
  } mac_req_t;

  // coefficient memory access
  typedef struct packed {
    logic                 we;
    logic [COEF_AW-1:0]   waddr;
    logic signed [31:0]   wdata;
    logic [COEF_AW-1:0]   raddr;
  } coef_req_t;

  typedef logic signed [31:0] sig_rom_t [SIG_N+1];

  // unsigned long division by shift and subtract, only used to build the table
  function automatic longint unsigned tbl_udiv(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // sigmoid table, worked out at elaboration
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t          rom;
    longint            d;
    longint unsigned   mag, a, u, term, e, den, num;
    longint            sum;
    for (int i = 0; i <= SIG_N; i++) begin
      d   = 16 * longint'(i) - 8 * longint'(SIG_N);
      mag = longint'(d < 0 ? -d : d);
      a   = (mag << 31) >> SIG_IDX_W;
      u   = a >> 8;
      term = 64'd1 << 31;
      sum  = longint'(64'd1 << 31);
      for (int k = 1; k <= 5; k++) begin
        term = tbl_udiv((term * u) >> 31, longint'(k));
        if ((k & 1) != 0) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      e = longint'(sum);
      for (int k = 0; k < 8; k++) e = (e * e + (64'd1 << 30)) >> 31;
      den = (64'd1 << 31) + e;
      num = (d >= 0) ? (64'd1 << 31) : e;
      rom[i] = 32'(tbl_udiv((num << FRAC_BITS) + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

[rtl/core/mlp_synaptic_weight_update_top.sv]
// top level: handshakes, configuration registers and the network sequencer
// depends on mlpswu_pkg, mlpswu_mac, mlpswu_sigmoid, mlpswu_coef_mem
//
// A load item (func 0), an unused code or any item while learn_rate is not positive
// is answered in the cycle after acceptance with the weight echoed and delta zero.
// A spike update runs the 7-4-2-1 network through one multiply-accumulate unit and
// the coefficient memory's single read port: each of the 42 multiply or bias terms
// is a read step then an accumulate step, each of the seven sigmoids a lookup step
// then an interpolation step, followed by the learning-rate product and the clip;
// the result is registered as the clip ends, and only then can a new item be taken.
// The input is stalled while an update runs or while a result waits to be taken.
module mlp_synaptic_weight_update_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [5:0]           coef_index_i,
  input  logic signed [31:0]   coef_value_i,
  input  logic signed [31:0]   pre_trace_fast_i,
  input  logic signed [31:0]   pre_trace_slow_i,
  input  logic signed [31:0]   post_trace_fast_i,
  input  logic signed [31:0]   post_trace_slow_i,
  input  logic [30:0]          weight_i,
  input  logic signed [31:0]   membrane_i,
  input  logic signed [31:0]   conductance_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [30:0]          new_weight_o,
  output logic signed [31:0]   delta_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import mlpswu_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_MAC   = 7'b0000100,
    S_SIG1  = 7'b0001000,
    S_SIG2  = 7'b0010000,
    S_DELTA = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] lr_q;
  logic [30:0]        max_q;

  logic signed [31:0] ops_q [7];
  logic signed [31:0] h_q [4];
  logic signed [31:0] o_q [2];
  logic signed [31:0] t_q;
  logic [30:0]        weight_q;
  logic               side_q;
  logic [1:0]         layer_q;
  logic [1:0]         nrn_q;
  logic [2:0]         term_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [31:0] lo_q, diff_q;
  logic [15:0]        frac_q;

  logic               out_valid_q;
  logic [30:0]        out_nw_q;
  logic signed [31:0] out_delta_q;

  mac_req_t           mac_req;
  logic signed [ACC_W-1:0] mac_sum;
  coef_req_t          coef_req;
  logic signed [31:0] coef_rdata;
  logic signed [ACC_W-1:0] sig_arg;
  logic signed [31:0] sig_lo, sig_diff;
  logic [15:0]        sig_frac;

  logic               in_acc, lr_pos, echo, slot_free, last_term;
  logic signed [31:0] op_a;
  logic signed [31:0] delta_sat;
  logic signed [33:0] nw_raw;
  logic [30:0]        nw_clip;
  logic signed [31:0] sig_val;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !slot_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign lr_pos     = !lr_q[31] && (lr_q != 32'sd0);
  assign echo       = (func_i == FUNC_LOAD) || (func_i == FUNC_UNUSED) || !lr_pos;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= 32'sd0;
      max_q <= 31'(1) << FRAC_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LEARN_RATE: lr_q  <= cfg_data_i;
        CFG_MAX_WEIGHT: max_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // coefficient write request and the read address of the current term
  always_comb begin
    coef_req.we    = in_acc && (func_i == FUNC_LOAD) && (coef_index_i < 6'(COEF_COUNT));
    coef_req.waddr = coef_index_i;
    coef_req.wdata = coef_value_i;
    unique case (layer_q)
      2'd0:    coef_req.raddr = {1'b0, nrn_q, term_q};
      2'd1:    coef_req.raddr = (side_q ? L2_POST_BASE : L2_PRE_BASE)
                                + {3'b000, nrn_q[0], term_q[1:0]};
      default: coef_req.raddr = (side_q ? OUT_POST_BASE : OUT_PRE_BASE)
                                + {5'd0, term_q[0]};
    endcase
  end

  mlpswu_coef_mem u_coef_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (coef_req),
    .rdata_o (coef_rdata)
  );

  // operand of the current term
  always_comb begin
    unique case (layer_q)
      2'd0:    op_a = (term_q == 3'd7) ? 32'sd0 : ops_q[term_q];
      2'd1:    op_a = h_q[term_q[1:0]];
      default: op_a = o_q[term_q[0]];
    endcase
  end

  always_comb begin
    unique case (layer_q)
      2'd0:    last_term = (term_q == 3'd7);
      2'd1:    last_term = (term_q == 3'd3);
      default: last_term = (term_q == 3'd1);
    endcase
  end

  // shared unit request per step
  always_comb begin
    mac_req.a           = op_a;
    mac_req.b           = coef_rdata;
    mac_req.addend      = acc_q;
    mac_req.short_shift = 1'b0;
    unique case (state_q)
      S_SIG2: begin
        mac_req.a           = diff_q;
        mac_req.b           = {16'd0, frac_q};
        mac_req.addend      = ACC_W'(lo_q);
        mac_req.short_shift = 1'b1;
      end
      S_DELTA: begin
        mac_req.a      = lr_q;
        mac_req.b      = t_q;
        mac_req.addend = '0;
      end
      default: ;
    endcase
  end

  mlpswu_mac u_mac (
    .req_i (mac_req),
    .sum_o (mac_sum)
  );

  // output unit takes tanh as 2*sigmoid(2y)-1
  assign sig_arg = (layer_q == 2'd2) ? (acc_q <<< 1) : acc_q;

  mlpswu_sigmoid u_sigmoid (
    .x_i    (sig_arg),
    .lo_o   (sig_lo),
    .diff_o (sig_diff),
    .frac_o (sig_frac)
  );

  assign sig_val = mac_sum[31:0];

  // saturate delta and clip the weight
  always_comb begin
    if (acc_q > ACC_W'(64'sd2147483647)) delta_sat = 32'sh7fffffff;
    else if (acc_q < -ACC_W'(64'sd2147483648)) delta_sat = 32'sh80000000;
    else delta_sat = acc_q[31:0];
    nw_raw = {3'b000, weight_q} + 34'(delta_sat);
    if (nw_raw > $signed({3'b000, max_q})) nw_clip = max_q;
    else if (nw_raw < 34'sd0) nw_clip = '0;
    else nw_clip = nw_raw[30:0];
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && !echo) state_d = S_RD;
      S_RD:    state_d = S_MAC;
      S_MAC:   state_d = last_term ? S_SIG1 : S_RD;
      S_SIG1:  state_d = S_SIG2;
      S_SIG2:  state_d = (layer_q == 2'd2) ? S_DELTA : S_RD;
      S_DELTA: state_d = S_FIN;
      S_FIN:   if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      layer_q     <= 2'd0;
      nrn_q       <= 2'd0;
      term_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_acc) begin
        layer_q <= 2'd0;
        nrn_q   <= 2'd0;
        term_q  <= 3'd0;
      end else if (state_q == S_MAC && !last_term) begin
        term_q <= term_q + 3'd1;
      end else if (state_q == S_SIG2) begin
        term_q <= 3'd0;
        unique case (layer_q)
          2'd0: begin
            if (nrn_q == 2'd3) begin
              layer_q <= 2'd1;
              nrn_q   <= 2'd0;
            end else begin
              nrn_q <= nrn_q + 2'd1;
            end
          end
          2'd1: begin
            if (nrn_q == 2'd1) begin
              layer_q <= 2'd2;
              nrn_q   <= 2'd0;
            end else begin
              nrn_q <= nrn_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
      if ((state_q == S_IDLE && in_acc && echo) || (state_q == S_FIN && slot_free)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      ops_q[0] <= pre_trace_fast_i;
      ops_q[1] <= pre_trace_slow_i;
      ops_q[2] <= post_trace_fast_i;
      ops_q[3] <= post_trace_slow_i;
      ops_q[4] <= {1'b0, weight_i};
      ops_q[5] <= membrane_i;
      ops_q[6] <= conductance_i;
      weight_q <= weight_i;
      side_q   <= (func_i == FUNC_POST);
      acc_q    <= '0;
      if (echo) begin
        out_nw_q    <= weight_i;
        out_delta_q <= 32'sd0;
      end
    end
    unique case (state_q)
      S_MAC: begin
        if (layer_q == 2'd0 && term_q == 3'd7) acc_q <= acc_q + ACC_W'(coef_rdata);
        else acc_q <= mac_sum;
      end
      S_SIG1: begin
        lo_q   <= sig_lo;
        diff_q <= sig_diff;
        frac_q <= sig_frac;
      end
      S_SIG2: begin
        acc_q <= '0;
        unique case (layer_q)
          2'd0:    h_q[nrn_q] <= sig_val;
          2'd1:    o_q[nrn_q[0]] <= sig_val;
          default: t_q <= (sig_val <<< 1) - (32'sd1 <<< FRAC_BITS);
        endcase
      end
      S_DELTA: acc_q <= mac_sum;
      S_FIN: begin
        if (slot_free) begin
          out_nw_q    <= nw_clip;
          out_delta_q <= delta_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign new_weight_o = out_nw_q;
  assign delta_o      = out_delta_q;

  // checks on the sequencer and the clip bound
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken while an update runs");

  a_layer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    layer_q != 2'd3)
    else $error("layer counter out of range");

  a_fin_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && slot_free) |=> (state_q == S_IDLE && out_valid_q))
    else $error("finished update not delivered");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_delta_q != 32'sd0) |-> (out_nw_q <= max_q))
    else $error("updated weight above the clip bound");

endmodule

[rtl/core/mlpswu_mac.sv]
// shared multiply-accumulate unit: addend + floor(a*b / 2^shift)
// depends on mlpswu_pkg
module mlpswu_mac (
  input  mlpswu_pkg::mac_req_t             req_i,
  output logic signed [mlpswu_pkg::ACC_W-1:0] sum_o
);
  import mlpswu_pkg::*;

  logic signed [63:0] prod;
  logic signed [63:0] shifted;

  // exact product, arithmetic shift rounds toward minus infinity
  assign prod    = 64'(req_i.a) * 64'(req_i.b);
  assign shifted = req_i.short_shift ? (prod >>> 16) : (prod >>> FRAC_BITS);
  assign sum_o   = shifted[ACC_W-1:0] + req_i.addend;

endmodule

[rtl/core/mlpswu_sigmoid.sv]
// sigmoid table lookup: clamp, index and interpolation fraction
// depends on mlpswu_pkg
module mlpswu_sigmoid (
  input  logic signed [mlpswu_pkg::ACC_W-1:0] x_i,
  output logic signed [31:0]                  lo_o,
  output logic signed [31:0]                  diff_o,
  output logic [15:0]                         frac_o
);
  import mlpswu_pkg::*;

  localparam logic signed [ACC_W-1:0] LIM = ACC_W'(1) <<< (FRAC_BITS + 3);

  logic signed [ACC_W-1:0] xc;
  logic signed [ACC_W-1:0] xs_full;
  logic [FRAC_BITS+3:0]    xs;
  logic [FRAC_BITS+3:0]    pw;
  logic [SIG_IDX_W-1:0]    idx;
  logic [SIG_IDX_W:0]      idx_lo;
  logic [SIG_IDX_W:0]      idx_hi;

  // clamp to [-8, 8 - 1 lsb]
  always_comb begin
    xc = x_i;
    if (x_i < -LIM) xc = -LIM;
    if (x_i > LIM - 1) xc = LIM - 1;
  end

  assign xs_full = xc + LIM;
  assign xs      = xs_full[FRAC_BITS+3:0];
  assign idx     = xs[FRAC_BITS+3 -: SIG_IDX_W];
  assign pw      = xs << SIG_IDX_W;
  assign frac_o  = pw[FRAC_BITS+3 -: 16];
  assign idx_lo  = {1'b0, idx};
  assign idx_hi  = {1'b0, idx} + 1'b1;

  assign lo_o   = SIG_ROM[idx_lo];
  assign diff_o = SIG_ROM[idx_hi] - SIG_ROM[idx_lo];

endmodule

[rtl/core/mlpswu_coef_mem.sv]
// coefficient memory, one write and one registered read port, entries read as zero until written
// depends on mlpswu_pkg
module mlpswu_coef_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlpswu_pkg::coef_req_t req_i,
  output logic signed [31:0]  rdata_o
);
  import mlpswu_pkg::*;

  logic signed [31:0]    mem [COEF_COUNT];
  logic [COEF_COUNT-1:0] valid_q;
  logic signed [31:0]    rdata_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= valid_q[req_i.raddr] ? mem[req_i.raddr] : 32'sd0;
  end

  assign rdata_o = rdata_q;

endmodule
